// File: hw/rtl/lz77d_pkg.sv
// Shared constants and types for the LZ77 token stream decoder.
// Used by lz77_token_stream_decoder; has no dependencies.
package lz77d_pkg;

  // History window depth in bytes. It must be a power of two between 256 and 65536.
  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

  localparam int BYTE_W   = 8;
  localparam int DIST_W   = 16;
  localparam int CMP_W    = DIST_W + 1;
  localparam int PACK_N   = 4;
  localparam int CNT_W    = 3;
  localparam int LEN_W    = 8;

  localparam logic [BYTE_W-1:0] MARK_LITERAL = 8'h00;
  localparam logic [BYTE_W-1:0] MARK_MATCH   = 8'hFF;

  typedef enum logic [2:0] {
    PH_MARKER  = 3'd0,
    PH_LITERAL = 3'd1,
    PH_DIST_LO = 3'd2,
    PH_DIST_HI = 3'd3,
    PH_LENGTH  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FLUSH
  } state_t;

endpackage

// File: hw/rtl/lz77d_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. Contents are undefined until written.
module lz77d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lz77_token_stream_decoder.sv
// LZ77 token stream decoder top level.
// Depends on lz77d_pkg and lz77d_ram.
//
// The block takes a compressed token stream one byte per request. A marker
// 0x00 makes the next byte a literal. A marker 0xFF is followed by a 16-bit
// little-endian distance and an 8-bit length, and that many bytes are copied
// from the history window. Other marker bytes are dropped. Decoded bytes
// leave packed up to four per result, with a count and a last flag on the
// final result of each input byte. A match whose distance is zero or reaches
// beyond the bytes decoded in this stream gives one error result with count 0.
// Header and marker bytes are taken while the block stays idle. A literal is
// accepted and then handed to the output register from the flush state. A match
// copy reads each byte from the history RAM in the read state and writes it
// back in the write state, since the RAM read port is registered, and passes
// the flush state for each result of up to four bytes. in_stall is high
// while a request is being worked on. A finished result waits in the output
// register, so the next request can be accepted while it is still stalled.
// The history RAM is not cleared after reset. Only bytes already written are
// ever read, so no clearing pass is needed.
module lz77_token_stream_decoder
  import lz77d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_stream_start,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte_0,
  output logic [BYTE_W-1:0] out_byte_1,
  output logic [BYTE_W-1:0] out_byte_2,
  output logic [BYTE_W-1:0] out_byte_3,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_last,
  output logic              out_error
);

  // Control state
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [HIST_AW-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload: match parameters, the pack buffer and the output register
  logic [DIST_W-1:0]              dist_r, dist_nxt;
  logic [LEN_W-1:0]               len_r, len_nxt;
  logic [PACK_N-1:0][BYTE_W-1:0]  pk_r, pk_nxt;
  logic [CNT_W-1:0]               pk_cnt_r, pk_cnt_nxt;
  logic                           pk_last_r, pk_last_nxt;
  logic                           pk_err_r, pk_err_nxt;
  logic [PACK_N-1:0][BYTE_W-1:0]  ob_r, ob_nxt;
  logic [CNT_W-1:0]               ocnt_r, ocnt_nxt;
  logic                           olast_r, olast_nxt;
  logic                           oerr_r, oerr_nxt;

  // History RAM port
  logic                ram_we;
  logic [HIST_AW-1:0]  ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [HIST_AW-1:0]  ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic                in_accept;
  logic                out_free;
  phase_t              phase_eff;
  logic [FILL_W-1:0]   fill_eff;
  logic                dist_bad;
  logic [HIST_AW-1:0]  wp_inc;
  logic [FILL_W-1:0]   fill_inc;

  lz77d_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  // A stream start restarts parsing and empties the history before the byte is used.
  // Only an accepted request counts; a waiting one must not touch the fill of a copy.
  assign phase_eff = in_stream_start ? PH_MARKER : phase_r;
  assign fill_eff  = (in_accept && in_stream_start) ? '0 : fill_r;
  assign dist_bad  = (dist_r == '0) || (CMP_W'(dist_r) > CMP_W'(fill_eff));

  assign wp_inc    = wp_r + {{(HIST_AW-1){1'b0}}, 1'b1};
  assign fill_inc  = (fill_eff < FILL_W'(HISTORY_DEPTH)) ? fill_eff + FILL_W'(1) : fill_eff;

  // The copy source is distance bytes behind the write pointer, modulo the window size.
  assign ram_raddr = wp_r - dist_r[HIST_AW-1:0];
  assign ram_re    = (state_r == ST_READ);
  assign ram_waddr = wp_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    dist_nxt      = dist_r;
    len_nxt       = len_r;
    pk_nxt        = pk_r;
    pk_cnt_nxt    = pk_cnt_r;
    pk_last_nxt   = pk_last_r;
    pk_err_nxt    = pk_err_r;
    ob_nxt        = ob_r;
    ocnt_nxt      = ocnt_r;
    olast_nxt     = olast_r;
    oerr_nxt      = oerr_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_wdata     = in_data_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          fill_nxt = fill_eff;
          unique case (phase_eff)
            PH_LITERAL: begin
              // Store the literal and send it as a one-byte result.
              ram_we      = 1'b1;
              wp_nxt      = wp_inc;
              fill_nxt    = fill_inc;
              pk_nxt      = '0;
              pk_nxt[0]   = in_data_byte;
              pk_cnt_nxt  = CNT_W'(1);
              pk_last_nxt = 1'b1;
              pk_err_nxt  = 1'b0;
              phase_nxt   = PH_MARKER;
              state_nxt   = ST_FLUSH;
            end
            PH_DIST_LO: begin
              dist_nxt  = {{(DIST_W-BYTE_W){1'b0}}, in_data_byte};
              phase_nxt = PH_DIST_HI;
            end
            PH_DIST_HI: begin
              dist_nxt  = {in_data_byte, dist_r[BYTE_W-1:0]};
              phase_nxt = PH_LENGTH;
            end
            PH_LENGTH: begin
              phase_nxt = PH_MARKER;
              pk_nxt    = '0;
              if (dist_bad) begin
                // Send an error result and copy nothing.
                pk_cnt_nxt  = '0;
                pk_last_nxt = 1'b1;
                pk_err_nxt  = 1'b1;
                state_nxt   = ST_FLUSH;
              end else if (in_data_byte != '0) begin
                len_nxt     = in_data_byte;
                pk_cnt_nxt  = '0;
                pk_last_nxt = 1'b0;
                pk_err_nxt  = 1'b0;
                state_nxt   = ST_READ;
              end
            end
            default: begin
              // Expect a marker. Drop unknown marker bytes.
              if (in_data_byte == MARK_LITERAL) begin
                phase_nxt = PH_LITERAL;
              end else if (in_data_byte == MARK_MATCH) begin
                phase_nxt = PH_DIST_LO;
              end else begin
                phase_nxt = PH_MARKER;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        // Write the copied byte back and add it to the pack buffer.
        ram_we                   = 1'b1;
        ram_wdata                = ram_rdata;
        wp_nxt                   = wp_inc;
        fill_nxt                 = fill_inc;
        pk_nxt[pk_cnt_r[1:0]]    = ram_rdata;
        pk_cnt_nxt               = pk_cnt_r + CNT_W'(1);
        len_nxt                  = len_r - LEN_W'(1);
        if (len_r == LEN_W'(1)) begin
          pk_last_nxt = 1'b1;
          state_nxt   = ST_FLUSH;
        end else if (pk_cnt_r == CNT_W'(PACK_N - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_READ;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          ob_nxt        = pk_r;
          ocnt_nxt      = pk_cnt_r;
          olast_nxt     = pk_last_r;
          oerr_nxt      = pk_err_r;
          out_valid_nxt = 1'b1;
          pk_nxt        = '0;
          pk_cnt_nxt    = '0;
          state_nxt     = pk_last_r ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MARKER;
      wp_r        <= '0;
      fill_r      <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    pk_r      <= pk_nxt;
    pk_cnt_r  <= pk_cnt_nxt;
    pk_last_r <= pk_last_nxt;
    pk_err_r  <= pk_err_nxt;
    ob_r      <= ob_nxt;
    ocnt_r    <= ocnt_nxt;
    olast_r   <= olast_nxt;
    oerr_r    <= oerr_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte_0 = ob_r[0];
  assign out_byte_1 = ob_r[1];
  assign out_byte_2 = ob_r[2];
  assign out_byte_3 = ob_r[3];
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;
  assign out_error  = oerr_r;

endmodule

// File: tb/tb.sv
// Self-checking testbench for lz77_token_stream_decoder.
// Depends on lz77d_pkg. A scoreboard class predicts the decoded result words and
// checks them; plain tasks drive token streams through the valid/stall channels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lz77d_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_PCT     = 8;
  localparam int RANDOM_REQS  = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 700;        // room for a length-255 copy to finish
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  // One result word of the decoder, as seen on the result channel.
  typedef struct packed {
    logic [PACK_N-1:0][BYTE_W-1:0] data;
    logic [CNT_W-1:0]              count;
    logic                          last;
    logic                          error;
  } out_word_t;

  // Scoreboard: tracks the decoder state, keeps the words still owed by the
  // block and compares each result word with the oldest one.
  class decoded_word_board;
    phase_t                    phase;
    logic [DIST_W-1:0]         match_dist;
    logic [HIST_AW-1:0]        wr_ptr;
    logic [FILL_W-1:0]         fill;
    logic [BYTE_W-1:0]         hist [HISTORY_DEPTH];
    out_word_t                 owed_words [$];
    int n_literals, n_matches, n_copied, n_dist_errors, n_dropped;
    int n_checked, n_mismatches;

    function new();
      phase      = PH_MARKER;
      match_dist = '0;
      wr_ptr     = '0;
      fill       = '0;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Append one word to the tail of the owed list.
    function void owe_word(out_word_t w);
      owed_words = {owed_words, w};
    endfunction

    function void push_history(logic [BYTE_W-1:0] v);
      hist[wr_ptr] = v;
      wr_ptr++;
      if (fill < HISTORY_DEPTH) fill++;
    endfunction

    // Advance the parser by one accepted request and queue the words it owes.
    function void decode_request(logic [BYTE_W-1:0] b, logic st);
      out_word_t          w;
      logic [HIST_AW-1:0] rd;
      logic [BYTE_W-1:0]  v;
      int                 slot;
      if (st) begin
        phase = PH_MARKER;
        fill  = '0;
      end
      w = '0;
      case (phase)
        PH_LITERAL: begin
          push_history(b);
          w.data[0] = b;
          w.count   = CNT_W'(1);
          w.last    = 1'b1;
          owe_word(w);
          n_literals++;
          phase = PH_MARKER;
        end
        PH_DIST_LO: begin
          match_dist = {8'h00, b};
          phase      = PH_DIST_HI;
        end
        PH_DIST_HI: begin
          match_dist[15:8] = b;
          phase            = PH_LENGTH;
        end
        PH_LENGTH: begin
          phase = PH_MARKER;
          if (match_dist == 0 || match_dist > fill) begin
            w.last  = 1'b1;
            w.error = 1'b1;
            owe_word(w);
            n_dist_errors++;
          end else begin
            n_matches++;
            slot = 0;
            for (int k = 0; k < int'(b); k++) begin
              rd = wr_ptr - match_dist[HIST_AW-1:0];
              v  = hist[rd];
              push_history(v);
              n_copied++;
              w.data[slot] = v;
              w.count      = CNT_W'(slot + 1);
              if (slot == PACK_N - 1 || k == int'(b) - 1) begin
                w.last = (k == int'(b) - 1);
                owe_word(w);
                w    = '0;
                slot = 0;
              end else begin
                slot++;
              end
            end
          end
        end
        default: begin
          if (b == MARK_LITERAL) phase = PH_LITERAL;
          else if (b == MARK_MATCH) phase = PH_DIST_LO;
          else begin
            phase = PH_MARKER;
            n_dropped++;
          end
        end
      endcase
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      logic      bad;
      if (owed_words.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: bytes=%h count=%0d last=%b error=%b",
                   $realtime, got.data, got.count, got.last, got.error);
        return;
      end
      want = owed_words.pop_front();
      n_checked++;
      bad = 1'b0;
      for (int i = 0; i < PACK_N; i++)
        if (got.data[i] !== want.data[i]) bad = 1'b1;
      if (got.count !== want.count) bad = 1'b1;
      if (got.last  !== want.last)  bad = 1'b1;
      if (got.error !== want.error) bad = 1'b1;
      if (bad) begin
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTS)
          $display({"[%0t] result mismatch: want bytes=%h count=%0d last=%b error=%b,",
                    " got bytes=%h count=%0d last=%b error=%b"},
                   $realtime, want.data, want.count, want.last, want.error,
                   got.data, got.count, got.last, got.error);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte    = '0;
  logic              in_stream_start = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [BYTE_W-1:0] out_byte_0, out_byte_1, out_byte_2, out_byte_3;
  logic [CNT_W-1:0]  out_count;
  logic              out_last, out_error;

  decoded_word_board sb = new();

  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  int n_requests   = 0;
  int cycle_cnt    = 0;
  bit hold_req     = 1'b0;
  bit saw_backpressure = 1'b0;

  lz77_token_stream_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_stream_start (in_stream_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_0      (out_byte_0),
    .out_byte_1      (out_byte_1),
    .out_byte_2      (out_byte_2),
    .out_byte_3      (out_byte_3),
    .out_count       (out_count),
    .out_last        (out_last),
    .out_error       (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: check every accepted word, then pick the next stall value.
  // Signals are read right after the edge, so they hold the values the edge saw.
  initial begin : result_sink
    out_word_t got;
    int        hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.data[0] = out_byte_0;
        got.data[1] = out_byte_1;
        got.data[2] = out_byte_2;
        got.data[3] = out_byte_3;
        got.count   = out_count;
        got.last    = out_last;
        got.error   = out_error;
        sb.check_word(got);
      end
      // Hold off for a long stretch when asked, counting the cycles here.
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Note when the input side is pushed back while the result side holds off.
  always @(posedge clk)
    if (rst_n && in_valid && in_stall && out_stall) saw_backpressure = 1'b1;

  // Offer one request, hold it until accepted, then hand it to the scoreboard.
  task automatic send_req(input logic [BYTE_W-1:0] b, input logic st);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_stream_start <= st;
    do @(posedge clk); while (in_stall);
    sb.decode_request(b, st);
    n_requests++;
  endtask

  task automatic send_literal(input logic [BYTE_W-1:0] v, input logic st);
    send_req(MARK_LITERAL, st);
    send_req(v, 1'b0);
  endtask

  task automatic send_match(input logic [DIST_W-1:0] d, input logic [LEN_W-1:0] len,
                            input logic st);
    send_req(MARK_MATCH, st);
    send_req(d[7:0], 1'b0);
    send_req(d[15:8], 1'b0);
    send_req(len, 1'b0);
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One random token. Mostly well-formed literals and matches; the rest are
  // bad distances, stray bytes and truncated matches. Restart the stream
  // whenever stray bytes left the parser in the middle of a token.
  task automatic send_random_token();
    int   pick, top, fill_now, d, len, r;
    logic st;
    pick     = $urandom_range(99);
    st       = (sb.phase != PH_MARKER) || (pick < 5);
    fill_now = int'(sb.fill);
    if (st) fill_now = 0;
    if (pick < 45 || (pick < 85 && fill_now == 0)) begin
      send_literal(BYTE_W'($urandom_range(255)), st);
    end else if (pick < 85) begin
      top = (fill_now > 64 && $urandom_range(3) != 0) ? 64 : fill_now;
      d   = $urandom_range(1, top);
      r   = $urandom_range(99);
      if (r < 85)      len = $urandom_range(0, 12);
      else if (r < 97) len = $urandom_range(13, 80);
      else             len = 255;
      send_match(DIST_W'(d), LEN_W'(len), st);
    end else if (pick < 92) begin
      // Bad distance: zero, one beyond the history, or far beyond it.
      r = $urandom_range(2);
      if (r == 0 || fill_now >= 65535) d = 0;
      else if (r == 1)                  d = fill_now + 1;
      else                              d = $urandom_range(fill_now + 1, 65535);
      send_match(DIST_W'(d), LEN_W'($urandom_range(255)), st);
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 3)) send_req(BYTE_W'($urandom_range(255)), 1'b0);
    end else begin
      // Truncated match, abandoned by the next stream start.
      send_req(MARK_MATCH, st);
      repeat ($urandom_range(0, 2)) send_req(BYTE_W'($urandom_range(255)), 1'b0);
      send_literal(BYTE_W'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin : stimulus
    int n_tokens;
    int target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: literal extremes, a dropped marker, zero distance,
    // an overlapping copy, a zero-length copy, a distance one beyond the
    // history with zero length, and a 255-byte copy (the most words per request).
    send_literal(8'hFF, 1'b1);
    send_literal(8'h00, 1'b0);
    send_req(8'h5A, 1'b0);
    send_literal(8'hA5, 1'b0);
    send_match(16'd0, 8'd5, 1'b0);
    send_match(16'd1, 8'd7, 1'b0);
    send_match(16'd10, 8'd0, 1'b0);
    send_match(16'd11, 8'd0, 1'b0);
    send_match(16'd3, 8'd255, 1'b0);

    // Random part, with one long result hold-off, a stretch without any
    // idling on either side, and one full drain of owed words.
    n_tokens = 0;
    target   = n_requests + RANDOM_REQS;
    while (n_requests < target) begin
      if (n_tokens == 40) hold_req = 1'b1;
      if (n_tokens == 70) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (n_tokens == 110) begin
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      if (n_tokens == 130) drain_results();
      send_random_token();
      n_tokens++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d literals, %0d copies of %0d bytes,",
             n_requests, sb.n_literals, sb.n_matches, sb.n_copied);
    $display("%0d bad distances, %0d dropped markers, %0d result words checked,",
             sb.n_dist_errors, sb.n_dropped, sb.n_checked);
    $display("%0d mismatches, input pushed back under hold-off: %0d.",
             sb.n_mismatches, saw_backpressure);
    if (sb.n_mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
